// ===== rtl/pwm_period_duty_meter_defines.svh =====
// Assertion macros for the PWM period and duty meter.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef PWM_PERIOD_DUTY_METER_DEFINES_SVH
`define PWM_PERIOD_DUTY_METER_DEFINES_SVH

`ifndef SYNTHESIS
`define PWMPDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwmpdm check failed");
`define PWMPDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwmpdm check failed");
`else
`define PWMPDM_ASSERT_IMP(lbl, ante, cons)
`define PWMPDM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pwmpdm_pkg.sv =====
`timescale 1ns / 1ps
package pwmpdm_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int STAMP_W       = COUNTER_WIDTH;
  localparam int PERIOD_W      = STAMP_W + 1;
  localparam int RATE_W        = 24;
  localparam int FREQ_W        = 24;
  localparam int DUTY_W        = 7;
  localparam int PROD_W        = STAMP_W + DUTY_W;
  localparam int DIV_W         = (RATE_W > PROD_W) ? RATE_W : PROD_W;
  localparam int DIV_CNT_W     = $clog2(DIV_W);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST       = DIV_CNT_W'(DIV_W - 1);
  localparam logic [DUTY_W-1:0]    DUTY_SCALE     = DUTY_W'(100);
  localparam logic [RATE_W-1:0]    TICK_RATE_RESET = RATE_W'(250000);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RISE1,
    ST_FALL,
    ST_RISE2,
    ST_PREP,
    ST_CHECK,
    ST_FDIV,
    ST_DSTART,
    ST_DDIV,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic cap_rise;
    logic cap_fall;
    logic cap_close;
    logic prep;
    logic div_start;
    logic div_duty;
    logic store_freq;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic zero_period;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/pwmpdm_in_if.sv =====
`timescale 1ns / 1ps
interface pwmpdm_in_if import pwmpdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic               edge_rising;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, output command, output edge_rising, output timestamp,
                  input ready);
  modport sink (input valid, input command, input edge_rising, input timestamp,
                output ready);
endinterface

// ===== rtl/pwmpdm_out_if.sv =====
`timescale 1ns / 1ps
interface pwmpdm_out_if import pwmpdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  frequency_hz;
  logic [DUTY_W-1:0]  duty_percent;
  logic [STAMP_W-1:0] high_ticks;
  logic [STAMP_W-1:0] low_ticks;
  logic               zero_period;

  modport source (output valid, output frequency_hz, output duty_percent,
                  output high_ticks, output low_ticks, output zero_period,
                  input ready);
  modport sink (input valid, input frequency_hz, input duty_percent,
                input high_ticks, input low_ticks, input zero_period,
                output ready);
endinterface

// ===== rtl/pwmpdm_divider.sv =====
`timescale 1ns / 1ps
module pwmpdm_divider import pwmpdm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic [DIV_W-1:0]    quotient,
  output logic                busy,
  output logic                done
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  dsr;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 fits;
  logic [PERIOD_W-1:0]  rem_next;

  // restoring step: bring down one dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    fits     = ~diff[PERIOD_W];
    rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/pwmpdm_datapath.sv =====
`timescale 1ns / 1ps
module pwmpdm_datapath import pwmpdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [RATE_W-1:0]    cfg_wr_data,
  input  logic [STAMP_W-1:0]   stamp,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  pwmpdm_out_if.source         out_ch
);

  logic [RATE_W-1:0]   tick_rate;
  logic [STAMP_W-1:0]  first_rise;
  logic [STAMP_W-1:0]  fall;
  logic [STAMP_W-1:0]  high_t;
  logic [STAMP_W-1:0]  low_t;
  logic [PERIOD_W-1:0] period;
  logic [PROD_W-1:0]   prod;
  logic [FREQ_W-1:0]   freq;
  logic                out_valid;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_quotient;
  logic                div_busy;
  logic                div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate <= cfg_wr_data;
    end
  end

  // tick counts wrap modulo the counter width
  always_ff @(posedge clk) begin
    if (cmd.cap_rise) begin
      first_rise <= stamp;
    end
    if (cmd.cap_fall) begin
      fall <= stamp;
    end
    if (cmd.cap_close) begin
      high_t <= fall - first_rise;
      low_t  <= stamp - fall;
    end
    if (cmd.prep) begin
      period <= {1'b0, high_t} + {1'b0, low_t};
      prod   <= PROD_W'(high_t) * PROD_W'(DUTY_SCALE);
    end
    if (cmd.store_freq) begin
      freq <= div_quotient[FREQ_W-1:0];
    end
  end

  assign div_dividend = cmd.div_duty ? DIV_W'(prod) : DIV_W'(tick_rate);

  pwmpdm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (period),
    .quotient (div_quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.high_ticks  <= high_t;
      out_ch.low_ticks   <= low_t;
      out_ch.zero_period <= sts.zero_period;
      if (sts.zero_period) begin
        out_ch.frequency_hz <= '0;
        out_ch.duty_percent <= '0;
      end else begin
        out_ch.frequency_hz <= freq;
        out_ch.duty_percent <= div_quotient[DUTY_W-1:0];
      end
    end
  end

  assign out_ch.valid = out_valid;

  always_comb begin
    sts.div_busy    = div_busy;
    sts.div_done    = div_done;
    sts.zero_period = (period == '0);
    sts.out_free    = ~out_valid | out_ch.ready;
  end

endmodule

// ===== rtl/pwmpdm_ctrl.sv =====
`timescale 1ns / 1ps
module pwmpdm_ctrl import pwmpdm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    command,
  input  logic    edge_rising,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;
  logic        start_beat;
  logic        edge_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_ready = (state == ST_IDLE) || (state == ST_RISE1) ||
               (state == ST_FALL) || (state == ST_RISE2);
  end

  assign accept     = in_valid & in_ready;
  assign start_beat = accept & (command == CMD_START);
  assign edge_beat  = accept & (command == CMD_EDGE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_beat) state_next = ST_RISE1;
      end
      ST_RISE1: begin
        if (start_beat) state_next = ST_RISE1;
        else if (edge_beat && edge_rising) state_next = ST_FALL;
      end
      ST_FALL: begin
        if (start_beat) state_next = ST_RISE1;
        else if (edge_beat && !edge_rising) state_next = ST_RISE2;
      end
      ST_RISE2: begin
        if (start_beat) state_next = ST_RISE1;
        else if (edge_beat && edge_rising) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // skip both divisions on an empty period
        state_next = sts.zero_period ? ST_LOAD : ST_FDIV;
      end
      ST_FDIV: begin
        if (sts.div_done) state_next = ST_DSTART;
      end
      ST_DSTART: begin
        state_next = ST_DDIV;
      end
      ST_DDIV: begin
        if (sts.div_done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.cap_rise   = (state == ST_RISE1) && edge_beat && edge_rising;
    cmd.cap_fall   = (state == ST_FALL) && edge_beat && !edge_rising;
    cmd.cap_close  = (state == ST_RISE2) && edge_beat && edge_rising;
    cmd.prep       = (state == ST_PREP);
    cmd.div_start  = ((state == ST_CHECK) && !sts.zero_period) || (state == ST_DSTART);
    cmd.div_duty   = (state == ST_DSTART);
    cmd.store_freq = (state == ST_FDIV) && sts.div_done;
    cmd.load_out   = (state == ST_LOAD) && sts.out_free;
  end

endmodule

// ===== rtl/pwm_period_duty_meter.sv =====
`timescale 1ns / 1ps
// PWM period and duty meter.
// in_ch carries one beat per command: command 0 arms the meter (and restarts a
// measurement in progress), command 1 is an edge event with its polarity and the
// 16-bit free-running counter value. Edges while idle or of the wrong polarity
// are dropped. Rising, falling, rising edges close one measurement.
// out_ch carries one beat per measurement: frequency, duty percent, high and low
// tick counts and a zero-period flag (frequency and duty forced to 0).
// cfg_wr_en/cfg_wr_data write the tick rate; write only while idle.
// Each input beat is taken in one cycle while the meter waits for edges. After
// the closing edge, input is held off while one shared 24-step restoring divider
// computes frequency then duty; both divisions are skipped when the period is zero.
// The result sits in an output register; a stalled receiver does not block the
// edges of the next measurement, but input is held off while its result waits.
// Synchronous reset returns to idle with the tick rate at 250000 Hz and no
// result pending.
`include "pwm_period_duty_meter_defines.svh"
module pwm_period_duty_meter import pwmpdm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data,
  pwmpdm_in_if.sink         in_ch,
  pwmpdm_out_if.source      out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pwmpdm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .command     (in_ch.command),
    .edge_rising (in_ch.edge_rising),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pwmpdm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stamp       (in_ch.timestamp),
    .cmd         (cmd),
    .sts         (sts),
    .out_ch      (out_ch)
  );

  `PWMPDM_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_ch.valid || out_ch.ready)
  `PWMPDM_ASSERT_IMP(a_no_input_while_div, in_ch.ready, !sts.div_busy)
  `PWMPDM_ASSERT_IMP(a_start_when_free, cmd.div_start, !sts.div_busy)
  `PWMPDM_ASSERT_NXT(a_load_shows, cmd.load_out, out_ch.valid)

endmodule
